>>> hw/rtl/blake2b_personalized_hash_core_assert.svh
// assertion macros for the personalized hash core
`ifndef BLAKE2B_PERSONALIZED_HASH_CORE_ASSERT_SVH
`define BLAKE2B_PERSONALIZED_HASH_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BPH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BPH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/bph_pkg.sv
// shared constants, tables and mixing function for the personalized hash core
package bph_pkg;

  localparam int unsigned Rounds = 12;

  typedef logic [63:0] word_t;

  typedef enum logic [2:0] {
    CFG_HASH_LEN = 3'd0,
    CFG_OUT_LEN  = 3'd1,
    CFG_N_PARAM  = 3'd2,
    CFG_K_PARAM  = 3'd3,
    CFG_PERSONAL = 3'd4
  } cfg_idx_e;

  localparam logic [63:0] ParamBase = 64'h0000_0000_0101_0000;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t w;
    case (i)
      3'd0: w = 64'h6a09e667f3bcc908;
      3'd1: w = 64'hbb67ae8584caa73b;
      3'd2: w = 64'h3c6ef372fe94f82b;
      3'd3: w = 64'ha54ff53a5f1d36f1;
      3'd4: w = 64'h510e527fade682d1;
      3'd5: w = 64'h9b05688c2b3e6c1f;
      3'd6: w = 64'h1f83d9abfb41bd6b;
      default: w = 64'h5be0cd19137e2179;
    endcase
    return w;
  endfunction

  // chain word after a reload: parameter word, personalization and proof parameters
  function automatic word_t chain_word(input logic [2:0] i, input logic [6:0] hl,
                                       input logic [63:0] pers, input logic [31:0] k,
                                       input logic [31:0] n);
    word_t w;
    w = iv_word(i);
    case (i)
      3'd0: w = w ^ ParamBase ^ {57'd0, hl};
      3'd6: w = w ^ pers;
      3'd7: w = w ^ {k, n};
      default: ;
    endcase
    return w;
  endfunction

  // message schedule, row = round mod 10, col = position 0..15
  function automatic logic [3:0] sigma(input logic [3:0] row, input logic [3:0] col);
    logic [63:0] r;
    case (row)
      4'd0: r = 64'hfedcba9876543210;
      4'd1: r = 64'h357b20c16df984ae;
      4'd2: r = 64'h491763eadf250c8b;
      4'd3: r = 64'h8f04a562ebcd1397;
      4'd4: r = 64'hd386cb1efa427509;
      4'd5: r = 64'h91ef57d438b0a6c2;
      4'd6: r = 64'hb8293670a4def15c;
      4'd7: r = 64'ha2684f05931ce7bd;
      4'd8: r = 64'h5a417d2c803b9ef6;
      default: r = 64'h0dc3e9bf5167482a;
    endcase
    return r[col*4 +: 4];
  endfunction

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  // one half of a mix step: (32,24) or (16,63) rotations
  function automatic quad_t half_mix(input quad_t q, input word_t m, input logic second);
    quad_t o;
    word_t t;
    o.a = q.a + q.b + m;
    t = q.d ^ o.a;
    o.d = second ? {t[15:0], t[63:16]} : {t[31:0], t[63:32]};
    o.c = q.c + o.d;
    t = q.b ^ o.c;
    o.b = second ? {t[62:0], t[63]} : {t[23:0], t[63:24]};
    return o;
  endfunction

endpackage

>>> hw/rtl/bph_mix_unit.sv
// combinational half mix step over four working words
module bph_mix_unit (
  input  logic            second_i,
  input  bph_pkg::quad_t  q_i,
  input  bph_pkg::word_t  m_i,
  output bph_pkg::quad_t  q_o
);
  assign q_o = bph_pkg::half_mix(q_i, m_i, second_i);
endmodule

>>> hw/rtl/blake2b_personalized_hash_core.sv
// BLAKE2b personalized hash core: message block memory, work vector, four mixing units
//
// Usage: s_axis carries one 64-bit message word per transfer; tdata holds the
// word and block_bytes above it, tlast marks the word that ends a block and
// tuser holds {restart, final_block} from bit 1 down. A restart word reloads the
// chain from IV and configuration and clears the byte counter. Words before the
// block end are taken back to back. The block-ending transfer is followed by a
// load state, the mix state (12 rounds of four half-mix steps, column then
// diagonal) and a finish state, after which input is ready again. After a final
// block with a nonzero output length the output state registers the digest words in
// order, one word per cycle while m_axis_tready is high;
// tdata holds the word and digest_index, tlast marks the last word. A stalled
// receiver holds the output register; input resumes the cycle after the last
// digest transfer. The block memory is a 16-entry synchronous array with four
// read ports; entries above the block end are masked, so no clearing pass runs.
// Reset loads the chain from the reset configuration values. Configuration
// writes on cfg_* are always accepted.
module blake2b_personalized_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // msg_word[63:0], block_bytes[7:0]
  input  logic        s_axis_tlast,   // block_end
  input  logic [1:0]  s_axis_tuser,   // final_block, restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // digest_word[63:0], digest_index[2:0], zero pad
  output logic        m_axis_tlast,   // digest_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [2:0] {ST_IN, ST_INIT, ST_MIX, ST_FIN, ST_OUT} state_e;

  state_e state_q;
  logic [6:0]  hash_len_q, out_len_q;
  logic [31:0] n_q, k_q;
  logic [63:0] pers_q;
  bph_pkg::word_t h_q [8];
  bph_pkg::word_t v_q [16];
  logic [63:0] cnt_q;
  logic [3:0]  pos_q, last_pos_q;
  logic        fin_q;
  logic [3:0]  round_q;
  logic [1:0]  step_q;   // {diag, second half}
  logic [3:0]  rrow_q;
  logic [2:0]  oidx_q;
  logic [3:0]  ocnt_q;

  // block memory with four read ports
  bph_pkg::word_t mem [16];
  bph_pkg::word_t rd_q [4];

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == ST_IN);
  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  logic [3:0] wpos;
  assign wpos = s_axis_tuser[1] ? 4'd0 : pos_q;

  // registered read ahead: address for the next step
  logic [1:0] nstep;
  logic [3:0] nrow;
  logic [3:0] naddr [4];
  always_comb begin
    nstep = step_q + 2'd1;
    nrow = rrow_q;
    if (state_q == ST_INIT) begin
      nstep = 2'd0;
      nrow = 4'd0;
    end else if (step_q == 2'd3) begin
      nrow = (rrow_q == 4'd9) ? 4'd0 : rrow_q + 4'd1;
    end
    for (int j = 0; j < 4; j++) begin
      naddr[j] = bph_pkg::sigma(nrow, {nstep[1], 2'(j), nstep[0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) mem[wpos] <= s_axis_tdata[63:0];
    for (int j = 0; j < 4; j++) begin
      rd_q[j] <= (naddr[j] > last_pos_q) ? '0 : mem[naddr[j]];
    end
  end

  // mixing units
  bph_pkg::quad_t qi [4];
  bph_pkg::quad_t qo [4];
  logic [3:0] ia [4], ib [4], ic [4], id [4];
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ia[j] = 4'(j);
      ib[j] = step_q[1] ? 4'(4 + ((j + 1) % 4)) : 4'(4 + j);
      ic[j] = step_q[1] ? 4'(8 + ((j + 2) % 4)) : 4'(8 + j);
      id[j] = step_q[1] ? 4'(12 + ((j + 3) % 4)) : 4'(12 + j);
      qi[j] = '{a: v_q[ia[j]], b: v_q[ib[j]], c: v_q[ic[j]], d: v_q[id[j]]};
    end
  end

  // mixing registers live in v_q; units compute combinationally into them
  for (genvar g = 0; g < 4; g++) begin : g_mix
    bph_mix_unit i_mix (
      .second_i (step_q[0]),
      .q_i      (qi[g]),
      .m_i      (rd_q[g]),
      .q_o      (qo[g])
    );
  end

  logic [6:0] olen;
  assign olen = (out_len_q > 7'd64) ? 7'd64 : out_len_q;
  logic [3:0] ototal;
  assign ototal = 4'((olen + 7'd7) >> 3);
  logic [6:0] orem;
  assign orem = olen - {1'b0, oidx_q, 3'b000};
  logic [63:0] omask;
  always_comb begin
    omask = '1;
    for (int b = 0; b < 8; b++) begin
      if (orem < 7'(b + 1)) omask[b*8 +: 8] = 8'h00;
    end
  end

  logic [7:0] bb;
  assign bb = (s_axis_tdata[71:64] > 8'd128) ? 8'd128 : s_axis_tdata[71:64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IN;
      hash_len_q <= 7'd50; out_len_q <= 7'd50;
      n_q <= 32'd200; k_q <= 32'd9;
      pers_q <= 64'd6300342813257196378;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= bph_pkg::chain_word(3'(i), 7'd50, 64'd6300342813257196378, 32'd9, 32'd200);
      end
      cnt_q <= '0; pos_q <= '0; last_pos_q <= '0; fin_q <= 1'b0;
      round_q <= '0; step_q <= '0; rrow_q <= '0; oidx_q <= '0; ocnt_q <= '0;
      m_axis_tvalid <= 1'b0; m_axis_tdata <= '0; m_axis_tlast <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          bph_pkg::CFG_HASH_LEN: hash_len_q <= cfg_data_i[6:0];
          bph_pkg::CFG_OUT_LEN:  out_len_q <= cfg_data_i[6:0];
          bph_pkg::CFG_N_PARAM:  n_q <= cfg_data_i[31:0];
          bph_pkg::CFG_K_PARAM:  k_q <= cfg_data_i[31:0];
          bph_pkg::CFG_PERSONAL: pers_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IN: begin
          if (in_fire) begin
            logic [63:0] c;
            c = s_axis_tuser[1] ? 64'd0 : cnt_q;
            if (s_axis_tuser[1]) begin
              for (int i = 0; i < 8; i++) begin
                h_q[i] <= bph_pkg::chain_word(3'(i), hash_len_q, pers_q, k_q, n_q);
              end
            end
            if (s_axis_tlast) begin
              cnt_q <= c + {56'd0, bb};
              last_pos_q <= wpos;
              fin_q <= s_axis_tuser[0];
              pos_q <= '0;
              state_q <= ST_INIT;
            end else begin
              cnt_q <= c;
              pos_q <= wpos + 4'd1;
            end
          end
        end
        ST_INIT: begin
          for (int i = 0; i < 8; i++) begin
            v_q[i] <= h_q[i];
            if (i == 4) v_q[12] <= bph_pkg::iv_word(3'd4) ^ cnt_q;
            else if (i == 6) v_q[14] <= bph_pkg::iv_word(3'd6) ^ {64{fin_q}};
            else v_q[i+8] <= bph_pkg::iv_word(3'(i));
          end
          round_q <= '0; step_q <= '0; rrow_q <= '0;
          state_q <= ST_MIX;
        end
        ST_MIX: begin
          for (int j = 0; j < 4; j++) begin
            v_q[ia[j]] <= qo[j].a; v_q[ib[j]] <= qo[j].b;
            v_q[ic[j]] <= qo[j].c; v_q[id[j]] <= qo[j].d;
          end
          step_q <= nstep; rrow_q <= nrow;
          if (step_q == 2'd3) begin
            round_q <= round_q + 4'd1;
            if (round_q == 4'(bph_pkg::Rounds - 1)) state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
          oidx_q <= '0; ocnt_q <= '0;
          state_q <= (fin_q && ototal != 4'd0) ? ST_OUT : ST_IN;
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            if (ocnt_q == ototal) begin
              m_axis_tvalid <= 1'b0;
              state_q <= ST_IN;
            end else begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata <= {5'd0, oidx_q, h_q[oidx_q] & omask};
              m_axis_tlast <= (ocnt_q + 4'd1 == ototal);
              oidx_q <= oidx_q + 3'd1;
              ocnt_q <= ocnt_q + 4'd1;
            end
          end
        end
        default: state_q <= ST_IN;
      endcase
    end
  end

`include "blake2b_personalized_hash_core_assert.svh"

  `BPH_ASSERT_IMP(a_no_in_while_out, m_axis_tvalid, !s_axis_tready)
  `BPH_ASSERT_IMP(a_pos_zero_mix, state_q == ST_MIX, pos_q == 4'd0)
  `BPH_ASSERT_NEXT(a_fin_to_in, state_q == ST_FIN && !fin_q, state_q == ST_IN)

endmodule

>>> tb/tb.sv
// self-checking testbench for the personalized blake2b hash core
`timescale 1ns / 100ps

module tb;

  localparam int WatchLimit = 3000;
  localparam int DrainCycles = 80;

  typedef struct {
    logic [63:0] msg;
    logic        blk_end;
    logic [7:0]  bytes;
    logic        fin;
    logic        restart;
  } msg_item_t;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  blake2b_personalized_hash_core i_dut (.*);

  always #4 clk_i = ~clk_i;

  // configuration copy
  logic [6:0]  hash_len_q, out_len_q;
  logic [31:0] n_param_q, k_param_q;
  logic [63:0] personal_q;

  // hash state copy
  logic [63:0] chain_q [8];
  logic [63:0] byte_cnt_q;
  logic [63:0] msg_blk_q [16];
  logic [3:0]  fill_pos_q;
  logic [63:0] work_q [16];

  msg_item_t pending_q [$];
  digest_t   digest_q [$];
  int        fail_cnt = 0;
  int        out_cnt = 0;
  bit        calm = 1'b0;
  bit        in_taken = 1'b0;
  int        in_gap = 0, out_gap = 0, hold_cnt = 0;
  bit        hold_done = 1'b0;
  int        idle_cnt = 0;

  int perm_tab [10][16] = '{
    '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
    '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
    '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
    '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
    '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
    '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
    '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
    '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
    '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
    '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
  };

  logic [63:0] init_vec [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] rotr(logic [63:0] w, int r);
    return (w >> r) | (w << (64 - r));
  endfunction

  task automatic mix_step(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
    work_q[a] = work_q[a] + work_q[b] + x;
    work_q[d] = rotr(work_q[d] ^ work_q[a], 32);
    work_q[c] = work_q[c] + work_q[d];
    work_q[b] = rotr(work_q[b] ^ work_q[c], 24);
    work_q[a] = work_q[a] + work_q[b] + y;
    work_q[d] = rotr(work_q[d] ^ work_q[a], 16);
    work_q[c] = work_q[c] + work_q[d];
    work_q[b] = rotr(work_q[b] ^ work_q[c], 63);
  endtask

  task automatic reload_chain();
    for (int i = 0; i < 8; i++) chain_q[i] = init_vec[i];
    chain_q[0] ^= 64'h0101_0000 | 64'(hash_len_q);
    chain_q[6] ^= personal_q;
    chain_q[7] ^= {k_param_q, n_param_q};
    byte_cnt_q = '0;
  endtask

  task automatic compress_block(bit last);
    int s;
    for (int i = 0; i < 8; i++) begin
      work_q[i] = chain_q[i];
      work_q[i+8] = init_vec[i];
    end
    // only the low counter word enters the work vector
    work_q[12] ^= byte_cnt_q;
    if (last) work_q[14] = ~work_q[14];
    for (int r = 0; r < 12; r++) begin
      s = r % 10;
      mix_step(0, 4,  8, 12, msg_blk_q[perm_tab[s][0]],  msg_blk_q[perm_tab[s][1]]);
      mix_step(1, 5,  9, 13, msg_blk_q[perm_tab[s][2]],  msg_blk_q[perm_tab[s][3]]);
      mix_step(2, 6, 10, 14, msg_blk_q[perm_tab[s][4]],  msg_blk_q[perm_tab[s][5]]);
      mix_step(3, 7, 11, 15, msg_blk_q[perm_tab[s][6]],  msg_blk_q[perm_tab[s][7]]);
      mix_step(0, 5, 10, 15, msg_blk_q[perm_tab[s][8]],  msg_blk_q[perm_tab[s][9]]);
      mix_step(1, 6, 11, 12, msg_blk_q[perm_tab[s][10]], msg_blk_q[perm_tab[s][11]]);
      mix_step(2, 7,  8, 13, msg_blk_q[perm_tab[s][12]], msg_blk_q[perm_tab[s][13]]);
      mix_step(3, 4,  9, 14, msg_blk_q[perm_tab[s][14]], msg_blk_q[perm_tab[s][15]]);
    end
    for (int i = 0; i < 8; i++) chain_q[i] ^= work_q[i] ^ work_q[i+8];
  endtask

  task automatic hash_word(msg_item_t it);
    int len, cnt, rem;
    digest_t d;
    if (it.restart) begin
      reload_chain();
      fill_pos_q = '0;
    end
    msg_blk_q[fill_pos_q] = it.msg;
    if (!it.blk_end) begin
      fill_pos_q = fill_pos_q + 4'd1;
      return;
    end
    for (int i = fill_pos_q + 1; i < 16; i++) msg_blk_q[i] = '0;
    fill_pos_q = '0;
    byte_cnt_q += (it.bytes > 8'd128) ? 64'd128 : 64'(it.bytes);
    compress_block(it.fin);
    if (!it.fin) return;
    len = (out_len_q > 7'd64) ? 64 : int'(out_len_q);
    cnt = (len + 7) / 8;
    for (int i = 0; i < cnt; i++) begin
      rem = len - 8 * i;
      d.word = chain_q[i];
      if (rem < 8) d.word &= (64'd1 << (8 * rem)) - 64'd1;
      d.index = 3'(i);
      d.last = (i + 1 == cnt);
      digest_q.push_back(d);
    end
  endtask

  // input side: accept at the rising edge, drive at the falling edge
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hash_word(pending_q.pop_front());
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap == 0 && !calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 3);
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_q[0].bytes, pending_q[0].msg};
        s_axis_tlast  <= pending_q[0].blk_end;
        s_axis_tuser  <= {pending_q[0].restart, pending_q[0].fin};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    digest_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      out_cnt++;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest transfer %h", $realtime, m_axis_tdata);
        fail_cnt++;
      end else begin
        e = digest_q.pop_front();
        if (m_axis_tdata[63:0] !== e.word || m_axis_tdata[66:64] !== e.index ||
            m_axis_tlast !== e.last) begin
          $display("%0t: digest mismatch exp word %h idx %0d last %0b, got %h idx %0d last %0b",
                   $realtime, e.word, e.index, e.last, m_axis_tdata[63:0],
                   m_axis_tdata[66:64], m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!hold_done && out_cnt >= 10) begin
      hold_done = 1'b1;
      hold_cnt = 250;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      if (out_gap == 0 && !calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 3);
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rst_ni;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WatchLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(bph_pkg::cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bph_pkg::CFG_HASH_LEN: hash_len_q = val[6:0];
      bph_pkg::CFG_OUT_LEN:  out_len_q = val[6:0];
      bph_pkg::CFG_N_PARAM:  n_param_q = val[31:0];
      bph_pkg::CFG_K_PARAM:  k_param_q = val[31:0];
      bph_pkg::CFG_PERSONAL: personal_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [6:0] hl, logic [6:0] ol, logic [31:0] n,
                            logic [31:0] k, logic [63:0] p);
    write_reg(bph_pkg::CFG_HASH_LEN, 64'(hl));
    write_reg(bph_pkg::CFG_OUT_LEN, 64'(ol));
    write_reg(bph_pkg::CFG_N_PARAM, 64'(n));
    write_reg(bph_pkg::CFG_K_PARAM, 64'(k));
    write_reg(bph_pkg::CFG_PERSONAL, p);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (digest_q.size() > 0) @(posedge clk_i);
    // a non-final block may still be compressing
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_word(logic [63:0] m, bit e, logic [7:0] b, bit f, bit r);
    msg_item_t it;
    it.msg = m;
    it.blk_end = e;
    it.bytes = b;
    it.fin = f;
    it.restart = r;
    pending_q.push_back(it);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // well-formed message of 1 to 3 blocks with random content
  task automatic push_message(ref int budget);
    int nblk, nw;
    logic [7:0] b;
    nblk = $urandom_range(1, 3);
    for (int k = 0; k < nblk; k++) begin
      nw = (k == nblk - 1) ? $urandom_range(1, 16) : 16;
      b = (k == nblk - 1) ? 8'($urandom_range(0, 128)) : 8'd128;
      if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(129, 255));
      for (int w = 0; w < nw; w++) begin
        push_word(rand_word(), w == nw - 1, (w == nw - 1) ? b : 8'($urandom),
                  (w == nw - 1) && (k == nblk - 1), (k == 0) && (w == 0));
        budget--;
      end
    end
  endtask

  task automatic push_noise(ref int budget);
    repeat ($urandom_range(1, 20)) begin
      push_word(rand_word(), $urandom_range(0, 7) == 0, 8'($urandom),
                $urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0);
      budget--;
    end
  endtask

  task automatic random_phase(int budget);
    while (budget > 0) begin
      if ($urandom_range(0, 5) == 0) push_noise(budget);
      else push_message(budget);
    end
  endtask

  initial begin
    hash_len_q = 7'd50;
    out_len_q  = 7'd50;
    n_param_q  = 32'd200;
    k_param_q  = 32'd9;
    personal_q = 64'd6300342813257196378;
    reload_chain();
    for (int i = 0; i < 16; i++) msg_blk_q[i] = '0;
    fill_pos_q = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: full block then an early-ending final block with oversized count
    push_word('1, 1'b0, 8'd0, 1'b0, 1'b1);
    for (int i = 1; i < 15; i++) begin
      push_word(64'(i) * 64'h0101_0101_0101_0101, 1'b0, 8'd0, 1'b0, 1'b0);
    end
    push_word(64'h8000_0000_0000_0001, 1'b1, 8'd128, 1'b0, 1'b0);
    push_word('0, 1'b1, 8'd255, 1'b1, 1'b0);
    // restart in the middle of a block, zero byte count
    push_word(64'h0123_4567_89ab_cdef, 1'b0, 8'd0, 1'b0, 1'b1);
    push_word(64'hfedc_ba98_7654_3210, 1'b1, 8'd0, 1'b1, 1'b1);
    // block after a final block keeps the chain
    push_word(64'h5555_aaaa_5555_aaaa, 1'b1, 8'd1, 1'b1, 1'b0);
    wait_drained();

    set_config(7'd64, 7'd64, 32'hffff_ffff, 32'd0, 64'd0);
    random_phase(55);
    wait_drained();

    set_config(7'd0, 7'd0, 32'd0, 32'hffff_ffff, '1);
    random_phase(20);
    wait_drained();

    set_config(7'd127, 7'd127, $urandom, $urandom, {$urandom, $urandom});
    random_phase(55);
    wait_drained();

    set_config(7'($urandom_range(0, 127)), 7'($urandom_range(1, 63)), $urandom, $urandom,
               {$urandom, $urandom});
    calm = 1'b1;
    random_phase(40);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0 && digest_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
